// ===== hw/rtl/ligp_pkg.sv =====
// ---------------------------------------------------------------------------
// ligp_pkg
// Shared types and constants for the longest increasing grid path block.
// ---------------------------------------------------------------------------
package ligp_pkg;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_FILL_RD,
      ST_FILL_NB,
      ST_FILL_WR,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_WALK_INIT,
      ST_WALK_RD,
      ST_WALK_EMIT,
      ST_WALK_NB,
      ST_WALK_CHK
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic store_cell;  // write the incoming cell, advance load count
      logic clear_load;  // drop a partial grid
      logic fill_start;  // start table fill at value 255, cell 0
      logic fill_adv;    // advance fill cursor
      logic nb_adv;      // advance direction counter
      logic nb_clr;      // restart direction scan
      logic fill_write;  // write table entry for current cell
      logic scan_start;  // start the maximum search
      logic scan_adv;    // advance the maximum search
      logic walk_start;  // load walk cursor from search result
      logic walk_move;   // step to the found neighbour
      logic emit;        // load the output register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic load_done;   // this cell completes the grid
      logic cell_match;  // current fill cell has current value
      logic fill_last;   // last cell of the last value
      logic nb_last;     // last direction
      logic scan_last;   // last cell of the search
      logic walk_last;   // remaining length reached one
      logic walk_found;  // a matching neighbour was found
   } status_type;

endpackage

// ===== hw/rtl/longest_increasing_grid_path.sv =====
// ---------------------------------------------------------------------------
// longest_increasing_grid_path
// Longest strictly increasing 4-neighbour path in a square grid.
// ---------------------------------------------------------------------------
// Usage: set csr_grid_side (side n, 0 acts as 1, above MAX_SIDE clamps),
// then send n*n cells row-major on req_*, one beat per cell. After the last
// cell the block fills a per-cell longest-path table by sweeping all 256
// values over every cell, four neighbour reads per matching cell. A maximum
// search and a walk setup state follow, then the path walk emits one rsp_*
// beat per path cell; the last beat carries rsp_last_cell.
// req_ready is low until the walk ends and while csr_write is high.
// A stalled rsp_ready holds the output register and the walk. Reset clears
// the load count and control state and sets the side to 8; a write to the
// side register drops a partially loaded grid.
// ---------------------------------------------------------------------------
module longest_increasing_grid_path #(
   parameter int MAX_SIDE = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_cell_value,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_path_cell,
   output logic [6:0] rsp_path_length,
   output logic       rsp_last_cell,
   input  logic       csr_write,
   input  logic [3:0] csr_grid_side
);
   import ligp_pkg::*;

   logic [3:0] side_ff;
   cmd_type    cmd;
   status_type sts;
   logic       rsp_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= 4'd8;
      end else if (csr_write) begin
         side_ff <= csr_grid_side;
      end
   end

   ligp_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready,
      .rsp_busy, .csr_write, .sts, .cmd
   );

   ligp_dp #(.MAX_SIDE(MAX_SIDE)) u_dp (
      .clock, .reset, .side(side_ff), .req_cell_value, .cmd, .sts,
      .rsp_valid, .rsp_ready, .rsp_busy, .rsp_path_cell,
      .rsp_path_length, .rsp_last_cell
   );

endmodule

// ===== hw/rtl/ligp_ctrl.sv =====
// ---------------------------------------------------------------------------
// ligp_ctrl
// Sequencer for loading, table fill, maximum search and path walk.
// ---------------------------------------------------------------------------
module ligp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 rsp_busy,
   input  logic                 csr_write,
   input  ligp_pkg::status_type sts,
   output ligp_pkg::cmd_type    cmd
);
   import ligp_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (!csr_write && req_valid && sts.load_done) state_in = ST_FILL_RD;
         end
         ST_FILL_RD: state_in = ST_FILL_NB;
         ST_FILL_NB: begin
            if (!sts.cell_match) begin
               state_in = sts.fill_last ? ST_SCAN_RD : ST_FILL_RD;
            end else if (sts.nb_last) begin
               state_in = ST_FILL_WR;
            end
         end
         ST_FILL_WR:   state_in = sts.fill_last ? ST_SCAN_RD : ST_FILL_RD;
         ST_SCAN_RD:   state_in = ST_SCAN_CMP;
         ST_SCAN_CMP:  state_in = sts.scan_last ? ST_WALK_INIT : ST_SCAN_RD;
         ST_WALK_INIT: state_in = ST_WALK_RD;
         ST_WALK_RD:   state_in = ST_WALK_EMIT;
         ST_WALK_EMIT: begin
            if (!rsp_busy) state_in = sts.walk_last ? ST_LOAD : ST_WALK_NB;
         end
         ST_WALK_NB: state_in = ST_WALK_CHK;
         ST_WALK_CHK: begin
            if (sts.walk_found) state_in = ST_WALK_RD;
            else if (sts.nb_last) state_in = ST_LOAD;
            else state_in = ST_WALK_NB;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_ready = !csr_write;
            cmd.clear_load = csr_write;
            cmd.store_cell = !csr_write && req_valid;
            cmd.fill_start = !csr_write && req_valid && sts.load_done;
         end
         ST_FILL_RD: cmd.nb_clr = 1'b1;
         ST_FILL_NB: begin
            if (!sts.cell_match) cmd.fill_adv = 1'b1;
            else if (!sts.nb_last) cmd.nb_adv = 1'b1;
         end
         ST_FILL_WR: begin
            cmd.fill_write = 1'b1;
            cmd.fill_adv   = 1'b1;
            cmd.scan_start = sts.fill_last;
         end
         ST_SCAN_CMP: cmd.scan_adv = 1'b1;
         ST_WALK_INIT: cmd.walk_start = 1'b1;
         ST_WALK_EMIT: begin
            cmd.emit   = !rsp_busy;
            cmd.nb_clr = 1'b1;
         end
         ST_WALK_CHK: begin
            if (sts.walk_found) cmd.walk_move = 1'b1;
            else cmd.nb_adv = 1'b1;
         end
         default: cmd = '0;
      endcase
      if (state_ff == ST_FILL_NB && !sts.cell_match && sts.fill_last) cmd.scan_start = 1'b1;
   end

endmodule

// ===== hw/rtl/ligp_dp.sv =====
// ---------------------------------------------------------------------------
// ligp_dp
// Grid and table memories, cursors, neighbour logic and output register.
// ---------------------------------------------------------------------------
module ligp_dp #(
   parameter int MAX_SIDE = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [3:0]           side,
   input  logic [7:0]           req_cell_value,
   input  ligp_pkg::cmd_type    cmd,
   output ligp_pkg::status_type sts,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_busy,
   output logic [7:0]           rsp_path_cell,
   output logic [6:0]           rsp_path_length,
   output logic                 rsp_last_cell
);
   import ligp_pkg::*;

   localparam int CELLS = MAX_SIDE * MAX_SIDE;
   localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int CW    = $clog2(CELLS + 1);
   localparam int SW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

   logic [7:0] grid_mem [CELLS];
   logic [6:0] len_mem  [CELLS];

   // Side in use, clamped.
   logic [4:0] n;
   always_comb begin
      if (side == 4'd0) n = 5'd1;
      else if ({1'b0, side} > 5'(MAX_SIDE)) n = 5'(MAX_SIDE);
      else n = {1'b0, side};
   end
   logic [CW-1:0] total;
   assign total = CW'(n * n);

   logic [CW-1:0] loaded_ff;
   logic [7:0]    fval_ff;
   logic [SW-1:0] row_ff, col_ff;
   logic [1:0]    dir_ff;
   logic [7:0]    cur_val_ff, nb_val_ff;
   logic [6:0]    best_ff, acc_ff, remain_ff, nb_len_ff;
   logic [SW-1:0] best_row_ff, best_col_ff;
   logic          nb_ok_ff;
   logic [AW-1:0] idx;

   assign idx = AW'(row_ff * n + col_ff);

   // Neighbour coordinates.
   logic [SW:0]   nr, nc;
   logic          nb_in;
   always_comb begin
      nr = {1'b0, row_ff};
      nc = {1'b0, col_ff};
      nb_in = 1'b1;
      case (dir_ff)
         2'd0: begin nb_in = (row_ff != '0); nr = {1'b0, row_ff} - 1'b1; end
         2'd1: begin nc = {1'b0, col_ff} + 1'b1; nb_in = (5'(nc) < n); end
         2'd2: begin nr = {1'b0, row_ff} + 1'b1; nb_in = (5'(nr) < n); end
         default: begin nb_in = (col_ff != '0); nc = {1'b0, col_ff} - 1'b1; end
      endcase
   end
   logic [AW-1:0] nb_idx;
   assign nb_idx = AW'(nr * n + nc);

   logic last_col, last_row;
   assign last_col = (5'(col_ff) == n - 5'd1);
   assign last_row = (5'(row_ff) == n - 5'd1);

   // Memory access: two registered read ports for each memory, one write.
   logic [AW-1:0] rd_addr;
   logic [7:0]    grid_rd_ff;
   logic [6:0]    len_rd_ff;
   logic [6:0]    fill_len;
   always_comb rd_addr = idx;

   logic [AW-1:0] rd_nb_addr;
   assign rd_nb_addr = nb_idx;

   always_ff @(posedge clock) begin
      if (cmd.store_cell) grid_mem[loaded_ff[AW-1:0]] <= req_cell_value;
      if (cmd.fill_write) len_mem[idx] <= fill_len + 7'd1;
      grid_rd_ff <= grid_mem[rd_addr];
      nb_val_ff  <= grid_mem[rd_nb_addr];
      len_rd_ff  <= len_mem[rd_addr];
      nb_len_ff  <= len_mem[rd_nb_addr];
      nb_ok_ff   <= nb_in;
   end

   logic [7:0] fval_in;
   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff <= '0;
      end else if (cmd.clear_load) begin
         loaded_ff <= '0;
      end else if (cmd.store_cell) begin
         loaded_ff <= cmd.fill_start ? '0 : loaded_ff + 1'b1;
      end
   end
   assign sts.load_done = (loaded_ff + 1'b1 >= total);

   // Fill: cursor (value, row, col); direction scan over four neighbours.
   assign fval_in = fval_ff - 8'd1;
   logic pos_last;
   assign pos_last = last_col && last_row;
   assign sts.fill_last = pos_last && (fval_ff == 8'd0);
   assign sts.cell_match = (grid_rd_ff == fval_ff);
   assign sts.nb_last = (dir_ff == 2'd3);
   assign sts.scan_last = pos_last;
   assign sts.walk_last = (remain_ff <= 7'd1);
   assign sts.walk_found = nb_ok_ff && (nb_val_ff > cur_val_ff) &&
                           (nb_len_ff == remain_ff - 7'd1);

   // The neighbour read lands in the cycle after dir changes; FILL_NB/WALK_CHK
   // sample it, so advance direction only after the sample (nb_adv).
   logic nb_hit;
   assign nb_hit = nb_ok_ff && (nb_val_ff > grid_rd_ff) && (nb_len_ff > acc_ff);

   // The left neighbour lands in FILL_WR itself: fold it into the write.
   assign fill_len = nb_hit ? nb_len_ff : acc_ff;

   logic nb_phase_ff;
   always_ff @(posedge clock) begin
      if (cmd.fill_start) begin
         fval_ff <= 8'd255;
         row_ff  <= '0;
         col_ff  <= '0;
      end else if (cmd.scan_start) begin
         row_ff  <= '0;
         col_ff  <= '0;
      end else if (cmd.fill_adv || cmd.scan_adv) begin
         if (last_col) begin
            col_ff <= '0;
            if (last_row) begin
               row_ff <= '0;
               if (cmd.fill_adv) fval_ff <= fval_in;
            end else begin
               row_ff <= row_ff + 1'b1;
            end
         end else begin
            col_ff <= col_ff + 1'b1;
         end
      end else if (cmd.walk_start) begin
         row_ff <= best_row_ff;
         col_ff <= best_col_ff;
      end else if (cmd.walk_move) begin
         row_ff <= nr[SW-1:0];
         col_ff <= nc[SW-1:0];
      end
      if (cmd.nb_clr) begin
         dir_ff <= 2'd0;
         acc_ff <= 7'd0;
      end else begin
         if (cmd.nb_adv) dir_ff <= dir_ff + 2'd1;
         if (nb_phase_ff && !cmd.walk_move && nb_hit) acc_ff <= nb_len_ff;
      end
      nb_phase_ff <= cmd.nb_adv;
      if (cmd.walk_start) remain_ff <= best_ff;
      else if (cmd.walk_move) remain_ff <= remain_ff - 7'd1;
      if (cmd.emit) cur_val_ff <= grid_rd_ff;
      if (cmd.scan_start) begin
         best_ff     <= 7'd0;
         best_row_ff <= '0;
         best_col_ff <= '0;
      end else if (cmd.scan_adv && len_rd_ff > best_ff) begin
         best_ff     <= len_rd_ff;
         best_row_ff <= row_ff;
         best_col_ff <= col_ff;
      end
   end

   // Output register.
   logic rsp_valid_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_path_cell   <= grid_rd_ff;
         rsp_path_length <= best_ff;
         rsp_last_cell   <= sts.walk_last;
      end
   end
   assign rsp_valid = rsp_valid_ff;
   assign rsp_busy  = rsp_valid_ff && !rsp_ready;

endmodule
